/* sv/bounded_deque_with_value_delete_unit_macros.svh */
// assertion macros used by the deque rtl
// no dependencies; clock and reset names follow the house port naming
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define BDVD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BDVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BDVD_ASSERT_IMPL(lbl, ante, cons, msg)
`define BDVD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/bdvd_pkg.sv */
// shared types and constants for the bounded deque with value delete
// no dependencies
`default_nettype none

package bdvd_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // action codes of an input beat
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_REM_VALUE = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command broadcast to every cell, already qualified by full/empty
  typedef struct packed {
    logic                  ins_front;
    logic                  ins_back;
    logic                  rem_front;
    logic                  rem_value;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/bounded_deque_with_value_delete_unit.sv */
// Bounded deque of 16-bit words with front/back insert and remove and
// removal of the first entry equal to a given word. Built as a row of
// CAPACITY cells that all compare and shift in the same cycle, so one
// command beat is taken every clock and busy_o never rises. The result beat
// appears on the cycle after the command is accepted, marked by done_o for
// exactly one cycle; the receiver cannot stall it and must take it then.
// Throughput is one beat per cycle, set by the single compare-and-shift
// pass through the cell row.
// depends on bdvd_pkg, bdvd_cell and the assertion macro header
`default_nettype none

`include "bounded_deque_with_value_delete_unit_macros.svh"

module bounded_deque_with_value_delete_unit
  import bdvd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2:0]            action_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic      [CNT_W-1:0]      count_o,
  output logic                       empty_res_o,
  output logic      [DATA_WIDTH-1:0] front_value_o,
  output logic      [DATA_WIDTH-1:0] back_value_o,
  output logic      [1:0]            status_o
);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q;
  status_e               status_q, status_d;
  status_e               status_pre;
  cmd_t                  cmd;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  rem_back;
  logic                  found;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]     seen;
  logic [CNT_W-1:0]      back_pos;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign empty  = (cnt_q == '0);

  // command decode and qualification
  always_comb begin
    cmd        = '0;
    cmd.value  = value_i;
    rem_back   = 1'b0;
    status_pre = ST_DONE;
    if (accept) begin
      case (action_e'(action_i))
        ACT_INS_FRONT: begin
          if (full) status_pre = ST_FULL;
          else      cmd.ins_front = 1'b1;
        end
        ACT_INS_BACK: begin
          if (full) status_pre = ST_FULL;
          else      cmd.ins_back = 1'b1;
        end
        ACT_REM_FRONT: begin
          if (empty) status_pre = ST_EMPTY;
          else       cmd.rem_front = 1'b1;
        end
        ACT_REM_BACK: begin
          if (empty) status_pre = ST_EMPTY;
          else       rem_back = 1'b1;
        end
        ACT_REM_VALUE: begin
          cmd.rem_value = 1'b1;
        end
        default: begin
          status_pre = ST_DONE;
        end
      endcase
    end
  end

  // value removal without a match reports empty
  assign status_d = (cmd.rem_value && !found) ? ST_EMPTY : status_pre;

  // cell row
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_head
      assign left = value_i;
    end else begin : g_body
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    bdvd_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .cnt_i   (cnt_q),
      .left_i  (left),
      .right_i (right),
      .seen_i  (seen[i]),
      .data_o  (cell_data[i]),
      .seen_o  (seen[i+1])
    );
  end
  assign found = seen[CAPACITY];

  // occupancy update
  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins_front || cmd.ins_back) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd.rem_front || rem_back || (cmd.rem_value && found)) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // control state and result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  // result view from the updated row
  assign back_pos      = cnt_q - CNT_W'(1);
  assign done_o        = done_q;
  assign count_o       = cnt_q;
  assign empty_res_o   = empty;
  assign front_value_o = empty ? '0 : cell_data[0];
  assign back_value_o  = empty ? '0 : cell_data[back_pos[IDX_W-1:0]];
  assign status_o      = status_q;

  `BDVD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `BDVD_ASSERT_NEXT(a_done_follows, accept, done_q, "accepted beat gave no result")
  `BDVD_ASSERT_NEXT(a_no_spurious, !accept, !done_q, "result without a command")
  `BDVD_ASSERT_IMPL(a_full_status, done_q && (status_q == ST_FULL),
                    cnt_q == CNT_W'(CAPACITY), "full status with room left")
  `BDVD_ASSERT_NEXT(a_step_one, !accept, cnt_q == $past(cnt_q),
                    "count moved without a command")

endmodule

`default_nettype wire

/* sv/bdvd_cell.sv */
// one storage cell of the deque row: holds one entry, shifts to/from neighbors
// depends on bdvd_pkg
`default_nettype none

module bdvd_cell
  import bdvd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire cmd_t                  cmd_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [CNT_W-1:0]      cnt_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic                  seen_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic                       seen_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid;
  logic                  is_tail;
  logic                  match;
  logic                  we;

  // occupancy view of this slot
  assign valid   = ({1'b0, idx_i} < cnt_i);
  assign is_tail = ({1'b0, idx_i} == cnt_i);

  // first-match chain: once a match is seen, this and later cells close the gap
  assign match  = valid && cmd_i.rem_value && (data_q == cmd_i.value);
  assign seen_o = seen_i | match;

  // next entry selection
  always_comb begin
    data_d = data_q;
    we     = 1'b0;
    if (cmd_i.ins_front) begin
      data_d = left_i;
      we     = 1'b1;
    end else if (cmd_i.ins_back && is_tail) begin
      data_d = cmd_i.value;
      we     = 1'b1;
    end else if (cmd_i.rem_front || (cmd_i.rem_value && seen_o)) begin
      data_d = right_i;
      we     = 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (we) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
